FILE: hw/rtl/alpha_blend_over_top_macros.svh
// Assertion helpers for the alpha blend block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ALPHA_BLEND_OVER_TOP_MACROS_SVH
`define ALPHA_BLEND_OVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define ABO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alpha_blend_over_top: assertion failed");

`define ABO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alpha_blend_over_top: assertion failed");

`else

`define ABO_ASSERT(lbl, prop)

`define ABO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/abo_pkg.sv
package abo_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned W_W          = 2 * PIX_W;
  localparam int unsigned NUM_W        = 3 * PIX_W;
  localparam int unsigned QUOT_W       = PIX_W;
  localparam int unsigned LANES        = 3;
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + QUOT_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HAS_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HAS_ALPHA = 1'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [W_W-1:0]   wgt_t;
  typedef logic [NUM_W-1:0] num_t;

  localparam pix_t PIX_MAX = '1;

  typedef struct packed {
    logic src_has_alpha;
    logic dst_has_alpha;
  } cfg_t;

  typedef struct packed {
    pix_t [LANES-1:0] src;
    pix_t [LANES-1:0] dst;
    pix_t             sa;
    pix_t             da;
  } blend_in_t;

  typedef struct packed {
    num_t [LANES-1:0] num;
    wgt_t             d;
    pix_t             alpha;
    logic             zero;
  } front_out_t;

endpackage

FILE: hw/rtl/abo_pix_if.sv
interface abo_pix_if import abo_pkg::*; ();
  logic valid;
  logic ready;
  pix_t src_red;
  pix_t src_green;
  pix_t src_blue;
  pix_t src_alpha;
  pix_t dst_red;
  pix_t dst_green;
  pix_t dst_blue;
  pix_t dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );

  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

FILE: hw/rtl/abo_res_if.sv
interface abo_res_if import abo_pkg::*; ();
  logic valid;
  logic ready;
  pix_t out_red;
  pix_t out_green;
  pix_t out_blue;
  pix_t out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

FILE: hw/rtl/alpha_blend_over_top.sv
// Source-over blend of straight-alpha RGBA pixels, exact integer result.
// Pipeline: 3 arithmetic stages, then one restoring-divider stage per
// quotient bit.
// Throughput: one pixel per cycle; each stage stalls only when full.
// Reset clears all stage valid bits and sets both has-alpha registers to 1.
`include "alpha_blend_over_top_macros.svh"

module alpha_blend_over_top import abo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  abo_pix_if.sink               pix_i,
  abo_res_if.source             res_o
);

  cfg_t                  cfg_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] vld_d;
  logic [PIPE_DEPTH-1:0] stage_rdy;

  blend_in_t        blend_in;
  front_out_t       front;
  pix_t [LANES-1:0] quot;

  pix_t              alpha_q [QUOT_W];
  logic [QUOT_W-1:0] zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_has_alpha: 1'b1, dst_has_alpha: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_HAS_ALPHA: cfg_q.src_has_alpha <= cfg_data_i[0];
        CFG_DST_HAS_ALPHA: cfg_q.dst_has_alpha <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its successor loads.
  always_comb begin
    stage_rdy[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || res_o.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stage_rdy[k] = !vld_q[k] || stage_rdy[k+1];
    end
  end

  assign vld_d = {vld_q[PIPE_DEPTH-2:0], pix_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (stage_rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign pix_i.ready = stage_rdy[0];

  assign blend_in.src[0] = pix_i.src_red;
  assign blend_in.src[1] = pix_i.src_green;
  assign blend_in.src[2] = pix_i.src_blue;
  assign blend_in.dst[0] = pix_i.dst_red;
  assign blend_in.dst[1] = pix_i.dst_green;
  assign blend_in.dst[2] = pix_i.dst_blue;
  assign blend_in.sa     = pix_i.src_alpha;
  assign blend_in.da     = pix_i.dst_alpha;

  abo_front u_front (
    .clk_i (clk_i),
    .en_i  (stage_rdy[FRONT_STAGES-1:0]),
    .cfg_i (cfg_q),
    .pix_i (blend_in),
    .res_o (front)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    abo_div u_div (
      .clk_i  (clk_i),
      .en_i   (stage_rdy[PIPE_DEPTH-1:FRONT_STAGES]),
      .num_i  (front.num[l]),
      .den_i  (front.d),
      .quot_o (quot[l])
    );
  end

  // alpha and the zero-weight flag ride alongside the divider
  always_ff @(posedge clk_i) begin
    if (stage_rdy[FRONT_STAGES]) begin
      alpha_q[0] <= front.alpha;
      zero_q[0]  <= front.zero;
    end
    for (int k = 1; k < QUOT_W; k++) begin
      if (stage_rdy[FRONT_STAGES+k]) begin
        alpha_q[k] <= alpha_q[k-1];
        zero_q[k]  <= zero_q[k-1];
      end
    end
  end

  assign res_o.valid     = vld_q[PIPE_DEPTH-1];
  assign res_o.out_red   = zero_q[QUOT_W-1] ? '0 : quot[0];
  assign res_o.out_green = zero_q[QUOT_W-1] ? '0 : quot[1];
  assign res_o.out_blue  = zero_q[QUOT_W-1] ? '0 : quot[2];
  assign res_o.out_alpha = alpha_q[QUOT_W-1];

  `ABO_ASSERT(a_dst_opaque, res_o.valid && !cfg_q.dst_has_alpha |-> res_o.out_alpha == PIX_MAX)
  `ABO_ASSERT(a_src_opaque, res_o.valid && !cfg_q.src_has_alpha |-> res_o.out_alpha == PIX_MAX)
  `ABO_ASSERT(a_clear_black, res_o.valid && res_o.out_alpha == '0 |->
    res_o.out_red == '0 && res_o.out_green == '0 && res_o.out_blue == '0)
  `ABO_ASSERT(a_full_when_stalled, !pix_i.ready |-> &vld_q)
  `ABO_ASSERT_NEXT(a_accept_lands, pix_i.valid && pix_i.ready, vld_q[0])

endmodule

FILE: hw/rtl/abo_front.sv
// Weights, products, numerators, combined weight and result alpha.
module abo_front import abo_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  cfg_t                    cfg_i,
  input  blend_in_t               pix_i,
  output front_out_t              res_o
);

  pix_t sa;
  pix_t da;
  wgt_t ws_d;
  wgt_t wd_d;
  logic [W_W:0] alpha_sum;

  pix_t [LANES-1:0] cs1_q;
  pix_t [LANES-1:0] cd1_q;
  wgt_t             ws1_q;
  wgt_t             wd1_q;

  num_t [LANES-1:0] ps2_q;
  num_t [LANES-1:0] pd2_q;
  wgt_t             d2_q;

  num_t [LANES-1:0] num3_q;
  wgt_t             d3_q;
  pix_t             alpha3_q;
  logic             zero3_q;

  // RGB formats read alpha as opaque
  assign sa = cfg_i.src_has_alpha ? pix_i.sa : PIX_MAX;
  assign da = cfg_i.dst_has_alpha ? pix_i.da : PIX_MAX;

  // sa*255 as a shift and subtract
  assign ws_d = {sa, {PIX_W{1'b0}}} - W_W'(sa);
  assign wd_d = W_W'(da) * W_W'(PIX_MAX - sa);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cs1_q <= pix_i.src;
      cd1_q <= pix_i.dst;
      ws1_q <= ws_d;
      wd1_q <= wd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int l = 0; l < LANES; l++) begin
        ps2_q[l] <= NUM_W'(cs1_q[l]) * NUM_W'(ws1_q);
        pd2_q[l] <= NUM_W'(cd1_q[l]) * NUM_W'(wd1_q);
      end
      d2_q <= ws1_q + wd1_q;
    end
  end

  // floor(d/255) = (d + 1 + (d >> 8)) >> 8, exact for d up to 65534
  assign alpha_sum = (W_W+1)'(d2_q) + (W_W+1)'(1) + (W_W+1)'(d2_q >> PIX_W);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int l = 0; l < LANES; l++) begin
        num3_q[l] <= ps2_q[l] + pd2_q[l];
      end
      d3_q     <= d2_q;
      alpha3_q <= alpha_sum[PIX_W +: PIX_W];
      zero3_q  <= (d2_q == '0);
    end
  end

  assign res_o.num   = num3_q;
  assign res_o.d     = d3_q;
  assign res_o.alpha = alpha3_q;
  assign res_o.zero  = zero3_q;

endmodule

FILE: hw/rtl/abo_div.sv
// Restoring divider, one quotient bit per stage, MSB first.
// Quotient fits QUOT_W bits since num <= 255 * den.
module abo_div import abo_pkg::*; (
  input  logic              clk_i,
  input  logic [QUOT_W-1:0] en_i,
  input  num_t              num_i,
  input  wgt_t              den_i,
  output pix_t              quot_o
);

  num_t rem_q  [QUOT_W-1];
  wgt_t den_q  [QUOT_W-1];
  pix_t quot_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    localparam int unsigned SH = QUOT_W - 1 - k;

    num_t         rem_in;
    wgt_t         den_in;
    pix_t         quot_in;
    num_t         trial;
    logic [NUM_W:0] diff;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign trial = NUM_W'(den_in) << SH;
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quot_q[k] <= {quot_in[QUOT_W-2:0], ~diff[NUM_W]};
      end
    end

    if (k < QUOT_W - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          den_q[k] <= den_in;
          rem_q[k] <= diff[NUM_W] ? rem_in : diff[NUM_W-1:0];
        end
      end
    end
  end

  assign quot_o = quot_q[QUOT_W-1];

endmodule

FILE: tb/sv/alpha_blend_over_top_tb.sv
module alpha_blend_over_top_tb;
  import abo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 4 * PIPE_DEPTH;

  typedef struct packed {
    pix_t sr;
    pix_t sg;
    pix_t sb;
    pix_t sa;
    pix_t dr;
    pix_t dg;
    pix_t db;
    pix_t da;
  } pix_pair_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
    pix_t a;
  } blended_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  abo_pix_if pix_if ();
  abo_res_if res_if ();

  alpha_blend_over_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  pix_pair_t   pixel_q[$];
  blended_t    blended_q[$];
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned err_cnt;
  int unsigned cyc_cnt;
  logic        idle_on;
  logic        pix_taken;
  logic        mdl_src_alpha;
  logic        mdl_dst_alpha;
  int unsigned pix_gap;
  int unsigned res_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Straight-alpha source-over, exact integer form.
  function automatic pix_t over_channel(input pix_t cs, input pix_t cd,
                                        input int unsigned ws, input int unsigned wd,
                                        input int unsigned d);
    int unsigned q;
    q = (cs * ws + cd * wd) / d;
    if (q > 255) q = 255;
    return pix_t'(q);
  endfunction

  function automatic blended_t blend_over(input pix_pair_t p, input logic s_has,
                                          input logic d_has);
    int unsigned sa;
    int unsigned da;
    int unsigned ws;
    int unsigned wd;
    int unsigned d;
    blended_t    o;
    sa = s_has ? p.sa : 255;
    da = d_has ? p.da : 255;
    ws = sa * 255;
    wd = da * (255 - sa);
    d  = ws + wd;
    if (d == 0) begin
      o = '0;
    end else begin
      o.r = over_channel(p.sr, p.dr, ws, wd, d);
      o.g = over_channel(p.sg, p.dg, ws, wd, d);
      o.b = over_channel(p.sb, p.db, ws, wd, d);
      o.a = pix_t'(d / 255);
    end
    return o;
  endfunction

  function automatic pix_pair_t mk_pair(input pix_t sr, input pix_t sg, input pix_t sb,
                                        input pix_t sa, input pix_t dr, input pix_t dg,
                                        input pix_t db, input pix_t da);
    pix_pair_t p;
    p = '{sr, sg, sb, sa, dr, dg, db, da};
    return p;
  endfunction

  function automatic pix_t rand_color();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return PIX_MAX;
    return pix_t'($urandom);
  endfunction

  // Alphas lean toward the edges where the division gets interesting.
  function automatic pix_t rand_alpha();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return PIX_MAX;
    if (r < 35) return 8'd1;
    if (r < 40) return 8'd254;
    return pix_t'($urandom);
  endfunction

  function automatic pix_pair_t rand_pair();
    return mk_pair(rand_color(), rand_color(), rand_color(), rand_alpha(),
                   rand_color(), rand_color(), rand_color(), rand_alpha());
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic push_pair(input pix_pair_t p);
    pixel_q.push_back(p);
    n_queued++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (!(n_taken == n_queued && blended_q.size() == 0));
  endtask

  task automatic set_alpha_modes(input logic s_has, input logic d_has);
    wait_drained();
    write_cfg(CFG_SRC_HAS_ALPHA, s_has);
    write_cfg(CFG_DST_HAS_ALPHA, d_has);
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pair(rand_pair());
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!pix_if.valid || pix_taken) begin
        if (pix_gap > 0) begin
          pix_gap--;
          pix_if.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          pix_pair_t p;
          p = pixel_q.pop_front();
          pix_if.src_red   <= p.sr;
          pix_if.src_green <= p.sg;
          pix_if.src_blue  <= p.sb;
          pix_if.src_alpha <= p.sa;
          pix_if.dst_red   <= p.dr;
          pix_if.dst_green <= p.dg;
          pix_if.dst_blue  <= p.db;
          pix_if.dst_alpha <= p.da;
          pix_if.valid     <= 1'b1;
          pix_gap = pick_gap();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_stall > 0) begin
        res_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        res_stall = pick_gap();
      end
    end
  end

  // Monitor: predict on input beats, check on result beats.
  always @(posedge clk_i) begin
    blended_t got;
    blended_t want;
    pix_pair_t p;
    if (rst_ni) begin
      pix_taken <= pix_if.valid && pix_if.ready;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SRC_HAS_ALPHA: mdl_src_alpha <= cfg_data_i[0];
          CFG_DST_HAS_ALPHA: mdl_dst_alpha <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.out_red, res_if.out_green, res_if.out_blue, res_if.out_alpha};
        if (blended_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result beat r=%0d g=%0d b=%0d a=%0d",
                     got.r, got.g, got.b, got.a);
        end else begin
          want = blended_q.pop_front();
          if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
              got.a !== want.a) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                       want.r, want.g, want.b, want.a, got.r, got.g, got.b, got.a);
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        p = '{pix_if.src_red, pix_if.src_green, pix_if.src_blue, pix_if.src_alpha,
              pix_if.dst_red, pix_if.dst_green, pix_if.dst_blue, pix_if.dst_alpha};
        blended_q.push_back(blend_over(p, mdl_src_alpha, mdl_dst_alpha));
        n_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    pix_if.valid  = 1'b0;
    pix_if.src_red   = '0;
    pix_if.src_green = '0;
    pix_if.src_blue  = '0;
    pix_if.src_alpha = '0;
    pix_if.dst_red   = '0;
    pix_if.dst_green = '0;
    pix_if.dst_blue  = '0;
    pix_if.dst_alpha = '0;
    res_if.ready  = 1'b0;
    n_queued      = 0;
    n_taken       = 0;
    err_cnt       = 0;
    cyc_cnt       = 0;
    idle_on       = 1'b1;
    pix_taken     = 1'b0;
    mdl_src_alpha = 1'b1;
    mdl_dst_alpha = 1'b1;
    pix_gap       = 0;
    res_stall     = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first, both sides carry alpha.
    push_pair(mk_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    push_pair(mk_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    // both alphas zero: all-zero result despite bright colors
    push_pair(mk_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
    push_pair(mk_pair(8'd200, 8'd100, 8'd50, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0));
    push_pair(mk_pair(8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd255));
    push_pair(mk_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd7, 8'd250, 8'd1, 8'd1));
    push_pair(mk_pair(8'd9, 8'd254, 8'd77, 8'd1, 8'd255, 8'd0, 8'd3, 8'd0));
    push_pair(mk_pair(8'd255, 8'd0, 8'd128, 8'd128, 8'd0, 8'd255, 8'd127, 8'd128));
    push_pair(mk_pair(8'd1, 8'd2, 8'd3, 8'd255, 8'd250, 8'd251, 8'd252, 8'd255));
    push_pair(mk_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255));
    push_pair(mk_pair(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1));
    push_pair(mk_pair(8'd255, 8'd255, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255));
    push_pair(mk_pair(8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255));
    push_pair(mk_pair(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55));
    push_pair(mk_pair(8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'hAA));
    push_pair(mk_pair(8'd255, 8'd1, 8'd254, 8'd127, 8'd0, 8'd254, 8'd1, 8'd3));

    // Source without alpha: src_alpha is ignored, reads as opaque.
    set_alpha_modes(1'b0, 1'b1);
    push_pair(mk_pair(8'd12, 8'd34, 8'd56, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
    push_pair(mk_pair(8'd255, 8'd0, 8'd255, 8'h5A, 8'd0, 8'd255, 8'd0, 8'd200));
    push_pair(rand_pair());
    // Destination without alpha: out_alpha must come back 255.
    set_alpha_modes(1'b1, 1'b0);
    push_pair(mk_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd40, 8'd80, 8'd120, 8'd0));
    push_pair(mk_pair(8'd255, 8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd0));
    push_pair(rand_pair());
    set_alpha_modes(1'b0, 1'b0);
    push_pair(mk_pair(8'd1, 8'd2, 8'd3, 8'd0, 8'd4, 8'd5, 8'd6, 8'd0));
    push_pair(mk_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    push_pair(rand_pair());

    set_alpha_modes(1'b1, 1'b1);
    push_random(480);
    set_alpha_modes(1'b0, 1'b1);
    push_random(200);
    set_alpha_modes(1'b1, 1'b0);
    push_random(200);
    set_alpha_modes(1'b0, 1'b0);
    push_random(150);
    // back-to-back stretch, no gaps on either side
    set_alpha_modes(1'b1, 1'b1);
    idle_on = 1'b0;
    push_random(200);
    wait_drained();
    idle_on = 1'b1;
    push_random(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (blended_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
